// File: src/cbmu_pkg.sv
// Shared types and constants for the cosine best-matching-unit search block.
`default_nettype none
package cbmu_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 2'd2;

    localparam logic [3:0] ROWS_RESET    = 4'd8;
    localparam logic [3:0] COLUMNS_RESET = 4'd8;
    localparam logic [8:0] DIMS_RESET    = 9'd256;

    localparam int FRAC_BITS = 14;
    localparam int QUO_W     = 18;
    localparam logic [QUO_W-1:0] QUO_CAP = 18'd131072;
    localparam logic signed [QUO_W+1:0] ONE_Q14 = 20'sd16384;
    localparam logic signed [QUO_W+1:0] TWO_Q14 = 20'sd32768;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         node_row;
        logic [2:0]         node_column;
        logic [7:0]         coord_index;
        logic signed [15:0] elem_value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  winner_row;
        logic [2:0]  winner_column;
        logic [15:0] dissimilarity;
        logic        no_match;
    } out_item_t;

endpackage
`default_nettype wire

// File: src/cbmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

// File: src/cbmu_sqrt.sv
// Iterative floor square root, one result bit per cycle.
`default_nettype none
module cbmu_sqrt #(
    parameter int IN_W = 39,
    localparam int OUT_W = (IN_W + 1) / 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [IN_W-1:0]  value,
    output logic                  done,
    output logic      [OUT_W-1:0] root
);

    localparam int RW  = 2 * OUT_W;
    localparam int CW  = $clog2(OUT_W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] bit_reg;
    logic [RW-1:0] trial;

    assign trial = root_reg + bit_reg;
    assign done  = busy_reg && (cnt_reg == '0);
    assign root  = root_reg[OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(OUT_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= RW'(value);
            root_reg <= '0;
            bit_reg  <= RW'(1) << (RW - 2);
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule
`default_nettype wire

// File: src/cbmu_div.sv
// Iterative restoring divider with a saturated quotient, one bit per cycle.
`default_nettype none
module cbmu_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 40
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [NUM_W-1:0]       num,
    input  wire logic [DEN_W-1:0]       den,
    output logic                        done,
    output logic [cbmu_pkg::QUO_W-1:0] quo
);
    import cbmu_pkg::*;

    localparam int W  = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
    localparam int CW = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsh_reg;
    logic [QUO_W-1:0] q_reg;
    logic             ovf;

    // Quotient would not fit the counted bits: go straight to the cap.
    assign ovf  = W'(num) >= (W'(den) << QUO_W);
    assign done = busy_reg && (cnt_reg == '0);
    assign quo  = (q_reg > QUO_CAP) ? QUO_CAP : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ovf ? '0 : CW'(QUO_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= W'(num);
            dsh_reg <= W'(den) << (QUO_W - 1);
            q_reg   <= ovf ? QUO_CAP : '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QUO_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule
`default_nettype wire

// File: src/cosine_best_matching_unit.sv
// Top level: cosine best-matching-unit search over a stored map codebook.
//
// Input channel (in_valid/in_stall/in_data) carries weight loads and query
// elements. A query element is taken without stalling; an in-range weight
// load holds in_stall high through its square old, square new and write back
// steps before the next item is taken. A query element with last set starts
// the search; in_stall stays high until the result is loaded into the output
// register.
// Search: the query norm is streamed and its root taken, then each usable
// node has its norm root taken, its dot product streamed, and a divide and
// compare done; a zero-norm node is skipped. The one multiplier, the root
// unit and the divider are shared across these steps.
// Output channel (out_valid/out_stall/out_data) is one register; a held
// result does not block new loads or query elements, only the next result.
// Configuration (cfg_valid/cfg_ready) is always ready; write it while idle.
// After reset the codebook and norm store are swept to zero, one entry a
// cycle, over all MAX_ROWS*MAX_COLUMNS*MAX_DIMS codebook entries (16384 by
// default), with in_stall high throughout.
`default_nettype none
module cosine_best_matching_unit #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int MAX_DIMS    = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire cbmu_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output cbmu_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cbmu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbmu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cbmu_pkg::*;

    localparam int NODES    = MAX_ROWS * MAX_COLUMNS;
    localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DIM_AW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CB_DEPTH = NODES * MAX_DIMS;
    localparam int CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
    localparam int DCNT_W   = $clog2(MAX_DIMS + 1);
    localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W   = $clog2(MAX_COLUMNS + 1);
    localparam int NORM_W   = 31 + $clog2(MAX_DIMS);
    localparam int DOT_W    = NORM_W + 1;
    localparam int SQRT_W   = (NORM_W + 1) / 2;
    localparam int MUL_W    = SQRT_W + 1;
    localparam int DEN_W    = 2 * SQRT_W;
    localparam int NUM_W    = DOT_W + FRAC_BITS;

    typedef enum logic [15:0] {
        S_CLEAR = 16'b0000_0000_0000_0001,
        S_IDLE  = 16'b0000_0000_0000_0010,
        S_WSQO  = 16'b0000_0000_0000_0100,
        S_WSQN  = 16'b0000_0000_0000_1000,
        S_WWR   = 16'b0000_0000_0001_0000,
        S_QNORM = 16'b0000_0000_0010_0000,
        S_QSQRT = 16'b0000_0000_0100_0000,
        S_NODE  = 16'b0000_0000_1000_0000,
        S_NNORM = 16'b0000_0001_0000_0000,
        S_NSQRT = 16'b0000_0010_0000_0000,
        S_DOT   = 16'b0000_0100_0000_0000,
        S_DEN   = 16'b0000_1000_0000_0000,
        S_DIV   = 16'b0001_0000_0000_0000,
        S_DIVW  = 16'b0010_0000_0000_0000,
        S_CMP   = 16'b0100_0000_0000_0000,
        S_DONE  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0] rows_reg, columns_reg;
    logic [8:0] dims_reg;

    logic [DCNT_W-1:0] eff_dims;
    logic [RCNT_W-1:0] eff_rows;
    logic [CCNT_W-1:0] eff_cols;

    logic [CB_AW-1:0]   clr_reg;
    logic [NODE_AW-1:0] wnode_reg;
    logic [CB_AW-1:0]   waddr_reg;
    logic signed [15:0] wval_reg;

    logic [DCNT_W-1:0] idx_reg;
    logic              p1_vld_reg, p2_vld_reg, qv_reg;
    logic              issue, stream_on, stream_done;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [DOT_W-1:0]   prod_t;
    logic signed [DOT_W-1:0]   acc_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic [SQRT_W-1:0]         sq_reg, sn_reg;

    logic [RCNT_W-1:0] rr_reg;
    logic [CCNT_W-1:0] cc_reg;
    logic [CB_AW-1:0]  cb_base_reg;
    logic              found_reg;
    logic [RCNT_W-1:0] best_r_reg;
    logic [CCNT_W-1:0] best_c_reg;
    logic [15:0]       best_d_reg;

    logic [MAX_DIMS-1:0] q_vld_reg;

    logic              in_xfer, w_in_range;
    logic [31:0]       in_node_full, in_addr_full, cur_node_full;
    logic [NODE_AW-1:0] cur_node;

    logic              cb_we, nn_we, q_we;
    logic [CB_AW-1:0]  cb_waddr, cb_raddr;
    logic [15:0]       cb_wdata, cb_rdata;
    logic [NODE_AW-1:0] nn_waddr, nn_raddr;
    logic [NORM_W-1:0] nn_wdata, nn_rdata;
    logic [15:0]       q_rdata;

    logic              sqrt_start, sqrt_done;
    logic [NORM_W-1:0] sqrt_in;
    logic [SQRT_W-1:0] sqrt_root;

    logic              div_start, div_done;
    logic [QUO_W-1:0]  div_quo;
    logic              dot_neg;
    logic [DOT_W-1:0]  dot_mag;

    logic signed [QUO_W+1:0] cos_s, d_raw;
    logic [15:0]             d_sat;
    logic                    last_node_col;
    logic                    out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= ROWS_RESET;
            columns_reg <= COLUMNS_RESET;
            dims_reg    <= DIMS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROWS:    rows_reg    <= cfg_data[3:0];
                REG_COLUMNS: columns_reg <= cfg_data[3:0];
                REG_DIMS:    dims_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Saturate the configured extents to the built size.
    assign eff_rows = (32'(rows_reg) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_reg);
    assign eff_cols = (32'(columns_reg) > MAX_COLUMNS) ? CCNT_W'(MAX_COLUMNS)
                                                       : CCNT_W'(columns_reg);
    assign eff_dims = (32'(dims_reg) > MAX_DIMS) ? DCNT_W'(MAX_DIMS) : DCNT_W'(dims_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    assign w_in_range = (32'(in_data.node_row) < MAX_ROWS)
                     && (32'(in_data.node_column) < MAX_COLUMNS)
                     && (32'(in_data.coord_index) < MAX_DIMS);
    assign in_node_full  = 32'(in_data.node_row) * MAX_COLUMNS + 32'(in_data.node_column);
    assign in_addr_full  = in_node_full * MAX_DIMS + 32'(in_data.coord_index);
    assign cur_node_full = 32'(rr_reg) * MAX_COLUMNS + 32'(cc_reg);
    assign cur_node      = NODE_AW'(cur_node_full);

    // Streaming walk over coordinates: issue read, multiply, accumulate.
    assign stream_on   = (state_reg == S_QNORM) || (state_reg == S_DOT);
    assign issue       = stream_on && (idx_reg < eff_dims);
    assign stream_done = stream_on && !issue && !p1_vld_reg && !p2_vld_reg;

    assign last_node_col = (32'(cc_reg) + 32'd1) >= 32'(eff_cols);
    assign out_free      = !out_valid || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (32'(clr_reg) == CB_DEPTH - 1) state_next = S_IDLE;
            S_IDLE:
                if (in_xfer)
                begin
                    if (in_data.opcode == OP_LOAD)
                    begin
                        if (w_in_range) state_next = S_WSQO;
                    end
                    else if (in_data.last)
                    begin
                        state_next = S_QNORM;
                    end
                end
            S_WSQO:  state_next = S_WSQN;
            S_WSQN:  state_next = S_WWR;
            S_WWR:   state_next = S_IDLE;
            S_QNORM:
                if (stream_done)
                    state_next = (acc_reg == '0) ? S_DONE : S_QSQRT;
            S_QSQRT:
                if (sqrt_done) state_next = S_NODE;
            S_NODE:
                if ((rr_reg >= eff_rows) || (eff_cols == '0)) state_next = S_DONE;
                else                                           state_next = S_NNORM;
            S_NNORM:
                state_next = (nn_rdata == '0) ? S_NODE : S_NSQRT;
            S_NSQRT:
                if (sqrt_done) state_next = S_DOT;
            S_DOT:
                if (stream_done) state_next = S_DEN;
            S_DEN:   state_next = S_DIV;
            S_DIV:   state_next = S_DIVW;
            S_DIVW:
                if (div_done) state_next = S_CMP;
            S_CMP:   state_next = S_NODE;
            S_DONE:
                if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            q_vld_reg  <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (q_we)
            begin
                q_vld_reg[DIM_AW'(32'(in_data.coord_index))] <= 1'b1;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                q_vld_reg <= '0;
                out_valid <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Shared multiplier operand select.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_WSQO:
            begin
                mul_a = MUL_W'(signed'(cb_rdata));
                mul_b = mul_a;
            end
            S_WSQN:
            begin
                mul_a = MUL_W'(wval_reg);
                mul_b = mul_a;
            end
            S_DEN:
            begin
                mul_a = signed'(MUL_W'(sq_reg));
                mul_b = signed'(MUL_W'(sn_reg));
            end
            default:
            begin
                mul_a = qv_reg ? MUL_W'(signed'(q_rdata)) : '0;
                mul_b = (state_reg == S_QNORM) ? mul_a : MUL_W'(signed'(cb_rdata));
            end
        endcase
    end

    assign prod_t = DOT_W'(prod_reg);

    assign dot_neg = dot_reg[DOT_W-1];
    assign dot_mag = dot_neg ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);

    always_comb
    begin
        cos_s = signed'({2'b00, div_quo});
        if (dot_neg)
        begin
            cos_s = -cos_s;
        end
        d_raw = ONE_Q14 - cos_s;
        if (d_raw < 0)
        begin
            d_sat = '0;
        end
        else if (d_raw > TWO_Q14)
        begin
            d_sat = 16'(TWO_Q14);
        end
        else
        begin
            d_sat = 16'(d_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            idx_reg <= idx_reg + 1'b1;
            qv_reg  <= q_vld_reg[idx_reg[DIM_AW-1:0]];
        end
        if ((state_reg == S_WSQO) || (state_reg == S_WSQN) || (state_reg == S_DEN)
            || p1_vld_reg)
        begin
            prod_reg <= mul_a * mul_b;
        end

        case (state_reg)
            S_IDLE:
            begin
                wnode_reg <= NODE_AW'(in_node_full);
                waddr_reg <= CB_AW'(in_addr_full);
                wval_reg  <= in_data.elem_value;
                idx_reg   <= '0;
                acc_reg   <= '0;
                found_reg <= 1'b0;
                rr_reg    <= '0;
                cc_reg    <= '0;
            end
            S_WSQO: acc_reg <= signed'(DOT_W'(nn_rdata));
            S_WSQN: acc_reg <= acc_reg - prod_t;
            S_QSQRT:
                if (sqrt_done) sq_reg <= sqrt_root;
            S_NODE:
                cb_base_reg <= CB_AW'(cur_node_full * MAX_DIMS);
            S_NNORM:
                if (nn_rdata == '0)
                begin
                    if (last_node_col)
                    begin
                        cc_reg <= '0;
                        rr_reg <= rr_reg + 1'b1;
                    end
                    else
                    begin
                        cc_reg <= cc_reg + 1'b1;
                    end
                end
            S_NSQRT:
                if (sqrt_done)
                begin
                    sn_reg  <= sqrt_root;
                    idx_reg <= '0;
                    acc_reg <= '0;
                end
            S_DOT:
                if (stream_done) dot_reg <= acc_reg;
            S_CMP:
            begin
                if (!found_reg || (d_sat < best_d_reg))
                begin
                    found_reg  <= 1'b1;
                    best_d_reg <= d_sat;
                    best_r_reg <= rr_reg;
                    best_c_reg <= cc_reg;
                end
                if (last_node_col)
                begin
                    cc_reg <= '0;
                    rr_reg <= rr_reg + 1'b1;
                end
                else
                begin
                    cc_reg <= cc_reg + 1'b1;
                end
            end
            default: ;
        endcase

        if (p2_vld_reg)
        begin
            acc_reg <= acc_reg + prod_t;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            if (found_reg)
            begin
                out_data.winner_row    <= 3'(best_r_reg);
                out_data.winner_column <= 3'(best_c_reg);
                out_data.dissimilarity <= best_d_reg;
                out_data.no_match      <= 1'b0;
            end
            else
            begin
                out_data.winner_row    <= '0;
                out_data.winner_column <= '0;
                out_data.dissimilarity <= '0;
                out_data.no_match      <= 1'b1;
            end
        end
    end

    // Memory ports.
    always_comb
    begin
        cb_we    = 1'b0;
        cb_waddr = waddr_reg;
        cb_wdata = wval_reg;
        nn_we    = 1'b0;
        nn_waddr = wnode_reg;
        nn_wdata = NORM_W'(acc_reg + prod_t);
        case (state_reg)
            S_CLEAR:
            begin
                cb_we    = 1'b1;
                cb_waddr = clr_reg;
                cb_wdata = '0;
                nn_we    = 32'(clr_reg) < NODES;
                nn_waddr = NODE_AW'(clr_reg);
                nn_wdata = '0;
            end
            S_WWR:
            begin
                cb_we = 1'b1;
                nn_we = 1'b1;
            end
            default: ;
        endcase
    end

    assign cb_raddr = (state_reg == S_IDLE) ? CB_AW'(in_addr_full)
                                            : cb_base_reg + CB_AW'(idx_reg);
    assign nn_raddr = (state_reg == S_IDLE) ? NODE_AW'(in_node_full) : cur_node;
    assign q_we     = in_xfer && (in_data.opcode == OP_QUERY)
                   && (32'(in_data.coord_index) < MAX_DIMS);

    cbmu_ram #(.WIDTH(16), .DEPTH(CB_DEPTH)) u_cb_ram (
        .clk     (clk),
        .wr_en   (cb_we),
        .wr_addr (cb_waddr),
        .wr_data (cb_wdata),
        .rd_addr (cb_raddr),
        .rd_data (cb_rdata)
    );

    cbmu_ram #(.WIDTH(NORM_W), .DEPTH(NODES)) u_nn_ram (
        .clk     (clk),
        .wr_en   (nn_we),
        .wr_addr (nn_waddr),
        .wr_data (nn_wdata),
        .rd_addr (nn_raddr),
        .rd_data (nn_rdata)
    );

    cbmu_ram #(.WIDTH(16), .DEPTH(MAX_DIMS)) u_q_ram (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (DIM_AW'(32'(in_data.coord_index))),
        .wr_data (in_data.elem_value),
        .rd_addr (idx_reg[DIM_AW-1:0]),
        .rd_data (q_rdata)
    );

    // Root unit serves the query norm, then each nonzero node norm.
    assign sqrt_start = ((state_reg == S_QNORM) && stream_done && (acc_reg != '0))
                     || ((state_reg == S_NNORM) && (nn_rdata != '0));
    assign sqrt_in    = (state_reg == S_QNORM) ? NORM_W'(acc_reg) : nn_rdata;

    cbmu_sqrt #(.IN_W(NORM_W)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sqrt_in),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign div_start = (state_reg == S_DIV);

    cbmu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({dot_mag, {FRAC_BITS{1'b0}}}),
        .den   (prod_reg[DEN_W-1:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

endmodule
`default_nettype wire

// File: src/cbmu_checker.sv
// Port-level checks for the cosine best-matching-unit block, bound to the top level.
`default_nettype none
module cbmu_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire cbmu_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire cbmu_pkg::out_item_t out_data
);
    import cbmu_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_match |->
            (out_data.winner_row == 3'd0) && (out_data.winner_column == 3'd0)
            && (out_data.dissimilarity == 16'd0))
        else $error("no_match result carries nonzero fields");

    a_dis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.dissimilarity <= 16'd32768)
        else $error("dissimilarity above two");

    a_search_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.opcode == OP_QUERY) && in_data.last
            |=> in_stall)
        else $error("input taken while search starts");

endmodule

bind cosine_best_matching_unit cbmu_checker u_cbmu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

// File: sim/cosine_best_matching_unit_test.sv
// Testbench for the cosine best-matching-unit search, checked against a predictor.
`timescale 1ns / 1ps
module cosine_best_matching_unit_test;
    import cbmu_pkg::*;

    localparam int NODES        = 64;
    localparam int DIMS         = 256;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int TARGET_ITEMS = 850;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    shortint         weights [NODES][DIMS];
    longint unsigned node_norm [NODES];
    shortint         query_vals [DIMS];
    int              rows_cfg;
    int              cols_cfg;
    int              dims_cfg;
    out_item_t       expected_winners [$];

    int  items_sent;
    int  mismatches;
    int  cycles;
    bit  idle_on;
    bit  hold_req;

    cosine_best_matching_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned t;
        root = 0;
        for (int b = 24; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            if (t * t <= v)
                root = t;
        end
        return root;
    endfunction

    function automatic int clip(input int v, input int top);
        return v > top ? top : v;
    endfunction

    function automatic out_item_t search_map();
        out_item_t       res;
        longint unsigned qn;
        longint unsigned sq;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned quo;
        longint          dot;
        longint          d;
        longint          best_d;
        bit              found;
        int              er;
        int              ec;
        int              ed;
        int              node;
        res = '0;
        qn = 0;
        found = 0;
        best_d = 0;
        er = clip(rows_cfg, 8);
        ec = clip(cols_cfg, 8);
        ed = clip(dims_cfg, DIMS);
        for (int i = 0; i < ed; i++)
            qn += longint'(query_vals[i]) * longint'(query_vals[i]);
        sq = isqrt(qn);
        if (qn != 0)
        begin
            for (int r = 0; r < er; r++)
            begin
                for (int c = 0; c < ec; c++)
                begin
                    node = r * 8 + c;
                    if (node_norm[node] == 0)
                        continue;
                    dot = 0;
                    for (int i = 0; i < ed; i++)
                        dot += longint'(query_vals[i]) * longint'(weights[node][i]);
                    den = sq * isqrt(node_norm[node]);
                    mag = dot < 0 ? -dot : dot;
                    quo = (mag << 14) / den;
                    if (quo > 131072)
                        quo = 131072;
                    d = dot < 0 ? 16384 + longint'(quo) : 16384 - longint'(quo);
                    if (d < 0)
                        d = 0;
                    if (d > 32768)
                        d = 32768;
                    if (!found || d < best_d)
                    begin
                        found = 1;
                        best_d = d;
                        res.winner_row = r[2:0];
                        res.winner_column = c[2:0];
                    end
                end
            end
        end
        if (found)
            res.dissimilarity = best_d[15:0];
        else
            res.no_match = 1'b1;
        return res;
    endfunction

    function automatic void apply_item(input in_item_t it);
        int      node;
        shortint prev;
        node = it.node_row * 8 + it.node_column;
        if (it.opcode == OP_LOAD)
        begin
            prev = weights[node][it.coord_index];
            node_norm[node] -= longint'(prev) * longint'(prev);
            node_norm[node] += longint'(it.elem_value) * longint'(it.elem_value);
            weights[node][it.coord_index] = it.elem_value;
        end
        else
        begin
            query_vals[it.coord_index] = it.elem_value;
            if (it.last)
            begin
                expected_winners.insert(expected_winners.size(), search_map());
                foreach (query_vals[i])
                    query_vals[i] = 0;
            end
        end
    endfunction

    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        apply_item(it);
        items_sent++;
    endtask

    task automatic load_weight(input int r, input int c, input int k, input int v,
                               input bit lst = 1'b0);
        in_item_t it;
        it = '0;
        it.opcode = OP_LOAD;
        it.node_row = r[2:0];
        it.node_column = c[2:0];
        it.coord_index = k[7:0];
        it.elem_value = v[15:0];
        it.last = lst;
        send_item(it);
    endtask

    task automatic query_elem(input int k, input int v, input bit lst);
        in_item_t it;
        it = '0;
        it.opcode = OP_QUERY;
        it.node_row = 3'($urandom);
        it.node_column = 3'($urandom);
        it.coord_index = k[7:0];
        it.elem_value = v[15:0];
        it.last = lst;
        send_item(it);
    endtask

    // wait until every expected result is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_winners.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_ROWS:    rows_cfg = v & 15;
            REG_COLUMNS: cols_cfg = v & 15;
            REG_DIMS:    dims_cfg = v & 511;
            default:     ;
        endcase
    endtask

    task automatic set_map(input int r, input int c, input int d);
        drain();
        write_reg(REG_ROWS, r);
        write_reg(REG_COLUMNS, c);
        write_reg(REG_DIMS, d);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 65535);
            1:       return $urandom_range(0, 255) - 128;
            2:       return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $urandom_range(0, 8191) - 4096;
        endcase
    endfunction

    task test_directed();
        load_weight(0, 0, 0, 32767);
        load_weight(7, 7, 255, -32768);
        load_weight(3, 4, 5, 4096, 1'b1);
        query_elem(0, 32767, 1'b1);
        query_elem(255, 1000, 1'b1);
        query_elem(17, 0, 1'b1);
        query_elem(5, -100, 1'b0);
        query_elem(5, 300, 1'b1);
        query_elem(0, 32767, 1'b0);
        query_elem(255, -32768, 1'b1);
        // same direction as a node: cosine may round past one
        load_weight(2, 2, 0, 3);
        load_weight(2, 2, 1, 3);
        query_elem(0, 5, 1'b0);
        query_elem(1, 5, 1'b1);
        // zero a node again so it is skipped
        load_weight(0, 0, 0, 0);
        query_elem(0, 100, 1'b1);
    endtask

    task test_register_extremes();
        set_map(0, 8, 256);
        query_elem(0, 500, 1'b1);
        set_map(15, 15, 511);
        query_elem(5, 4096, 1'b1);
        set_map(8, 0, 256);
        query_elem(5, 4096, 1'b1);
        set_map(8, 8, 0);
        query_elem(0, 4096, 1'b1);
        // weight beyond the searched dims still counts in the norm
        set_map(1, 1, 1);
        load_weight(0, 0, 200, 20000);
        load_weight(0, 0, 0, 1000);
        query_elem(0, 1000, 1'b1);
    endtask

    task automatic random_traffic(input int budget);
        int stop;
        int r;
        int c;
        int n;
        int k;
        int mode;
        stop = items_sent + budget;
        while (items_sent < stop)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
            begin
                n = clip(dims_cfg, DIMS);
                if (n == 0)
                    n = 1;
                for (int i = 0; i < n; i++)
                begin
                    k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : i;
                    query_elem(k, ($urandom_range(0, 9) == 0) ? 0 : pick_value(), i == n - 1);
                end
            end
            else if (mode < 8)
            begin
                r = $urandom_range(0, clip(rows_cfg, 8) == 0 ? 0 : clip(rows_cfg, 8) - 1);
                c = $urandom_range(0, clip(cols_cfg, 8) == 0 ? 0 : clip(cols_cfg, 8) - 1);
                n = clip(dims_cfg, DIMS);
                for (int i = 0; i < n; i++)
                    load_weight(r, c, i, ($urandom_range(0, 5) == 0) ? 0 : pick_value(),
                                $urandom_range(0, 1));
            end
            else if (mode == 8)
                load_weight($urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 255), $urandom_range(0, 65535),
                            $urandom_range(0, 1));
            else
                query_elem($urandom_range(0, 255), $urandom_range(0, 65535), 1'b0);
        end
    endtask

    task test_random();
        while (items_sent < TARGET_ITEMS - 120)
        begin
            set_map($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 10));
            random_traffic(100);
        end
    endtask

    task test_output_hold();
        set_map(3, 3, 4);
        hold_req = 1'b1;
        random_traffic(60);
    endtask

    task test_no_idle();
        drain();
        idle_on = 1'b0;
        set_map(2, 4, 6);
        random_traffic(60);
    endtask

    // receiver stalls: random bursts, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_winners.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: row %0d col %0d diss %0d no_match %0b",
                             out_data.winner_row, out_data.winner_column,
                             out_data.dissimilarity, out_data.no_match);
            end
            else
            begin
                out_item_t want;
                want = expected_winners.pop_front();
                if (out_data.winner_row !== want.winner_row
                    || out_data.winner_column !== want.winner_column
                    || out_data.dissimilarity !== want.dissimilarity
                    || out_data.no_match !== want.no_match)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected row %0d col %0d diss %0d nm %0b,",
                                  " got row %0d col %0d diss %0d nm %0b"},
                                 want.winner_row, want.winner_column, want.dissimilarity,
                                 want.no_match, out_data.winner_row, out_data.winner_column,
                                 out_data.dissimilarity, out_data.no_match);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** cosine_best_matching_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        mismatches = 0;
        items_sent = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        rows_cfg = ROWS_RESET;
        cols_cfg = COLUMNS_RESET;
        dims_cfg = DIMS_RESET;
        foreach (node_norm[n])
            node_norm[n] = 0;
        foreach (weights[n, i])
            weights[n][i] = 0;
        foreach (query_vals[i])
            query_vals[i] = 0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the clearing sweep lets go of the input
        do
            @(posedge clk);
        while (in_stall);

        test_directed();
        test_register_extremes();
        test_random();
        test_output_hold();
        test_no_idle();

        drain();
        if (mismatches == 0)
            $display("** cosine_best_matching_unit: PASSED **");
        else
            $display("** cosine_best_matching_unit: FAILED **");
        $finish;
    end

endmodule
